// ===== rtl/tbpf_pkg.sv =====
// ----------------------------------------------------------------------------
// tbpf_pkg
// Types, constants and helpers shared by the tile background pixel fetch.
// ----------------------------------------------------------------------------
package tbpf_pkg;

  // Video RAM geometry: bytes are stored as 16-bit even/odd pairs
  localparam int unsigned VramBytes  = 8192;
  localparam int unsigned VramAw     = $clog2(VramBytes);
  localparam int unsigned VramWords  = VramBytes / 2;
  localparam int unsigned VramWordAw = $clog2(VramWords);

  // Screen size
  localparam int unsigned ScreenColumns = 160;
  localparam int unsigned ScreenLines   = 144;

  // Tile map and tile data placement
  localparam logic [VramAw-1:0] MapLowBase     = VramAw'(13'h1800);
  localparam logic [VramAw-1:0] MapHighBase    = VramAw'(13'h1C00);
  localparam logic [VramAw-1:0] SignedTileBase = VramAw'(13'h0800);
  localparam logic [VramWordAw-1:0] SignedTileWord = SignedTileBase[VramAw-1:1];

  // Configuration register indexes
  localparam logic [1:0] RegScrollX       = 2'd0;
  localparam logic [1:0] RegScrollY       = 2'd1;
  localparam logic [1:0] RegMapSelect     = 2'd2;
  localparam logic [1:0] RegUnsignedTiles = 2'd3;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // Item kinds
  localparam logic KindWrite  = 1'b0;
  localparam logic KindRender = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [12:0] vram_addr;
    logic [7:0] vram_byte;
    logic [7:0] pixel_x;
    logic [7:0] line_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0] color_index;
    logic [7:0] shade;
    logic [7:0] out_x;
    logic [7:0] out_y;
  } out_item_t;

  typedef struct packed {
    logic [7:0] hscroll;
    logic [7:0] vscroll;
    logic       map_select;
    logic       unsigned_tiles;
  } cfg_t;

  // Gray level of a 2-bit color index
  function automatic logic [7:0] shade_of(input logic [1:0] color);
    logic [7:0] s;
    case (color)
      2'd0:    s = 8'd255;
      2'd1:    s = 8'd192;
      2'd2:    s = 8'd96;
      default: s = 8'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/tile_background_pixel_fetch.sv =====
// ----------------------------------------------------------------------------
// tile_background_pixel_fetch
// Tile map background renderer with its own 8 KiB video RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (valid/ready): a write item stores vram_byte at vram_addr and
//   gives no result; a render item fetches one background pixel. Render
//   items off screen give no result.
//   out channel (valid/ready): color index, gray shade and the pixel position.
//   cfg port: horizontal and vertical scroll, map select, tile numbering.
// Timing:
//   A render item passes map read, tile row read and pixel select, each
//   registered, before out_valid rises. One item is accepted per cycle
//   unless all stages are full and out is held; the two video RAM read ports
//   (map byte and tile row pair) serve different items in the same cycle.
// Reset:
//   Clears the registers and the pipeline; video RAM content is undefined
//   until written.
// Stall:
//   A held result stalls only the stages behind it; input stays ready while a
//   pipeline bubble is free.
// ----------------------------------------------------------------------------
module tile_background_pixel_fetch #(
  parameter int unsigned ScreenColumns = tbpf_pkg::ScreenColumns
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tbpf_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tbpf_pkg::out_item_t            out_data_o,
  input  logic                           cfg_we_i,
  input  logic [tbpf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tbpf_pkg::CfgDataW-1:0]  cfg_data_i
);

  tbpf_pkg::cfg_t cfg;

  tbpf_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Stage enables, from the output back
  logic en0, en1, en2;
  logic s1_valid_q, s2_valid_q, out_valid_q;

  assign en2 = !out_valid_q || out_ready_i;
  assign en1 = !s2_valid_q || en2;
  assign en0 = !s1_valid_q || en1;
  assign in_ready_o = en0;

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_o;

  // Stage 0: scroll and map address
  logic [7:0] bx0, by0;
  logic       on_screen;
  logic [tbpf_pkg::VramAw-1:0] map_addr;

  assign bx0 = in_data_i.pixel_x + cfg.hscroll;
  assign by0 = in_data_i.line_y + cfg.vscroll;
  assign on_screen = ({1'b0, in_data_i.pixel_x} < 9'(ScreenColumns))
                  && ({1'b0, in_data_i.line_y} < 9'(tbpf_pkg::ScreenLines));
  assign map_addr = (cfg.map_select ? tbpf_pkg::MapHighBase : tbpf_pkg::MapLowBase)
                  + tbpf_pkg::VramAw'({by0[7:3], bx0[7:3]});

  logic       s1_bsel_q;
  logic [2:0] s1_fine_x_q, s1_fine_y_q;
  logic [7:0] s1_x_q, s1_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en0) begin
      s1_valid_q <= in_xfer && (in_data_i.kind == tbpf_pkg::KindRender) && on_screen;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) begin
      s1_bsel_q   <= map_addr[0];
      s1_fine_x_q <= bx0[2:0];
      s1_fine_y_q <= by0[2:0];
      s1_x_q      <= in_data_i.pixel_x;
      s1_y_q      <= in_data_i.line_y;
    end
  end

  // Stage 1: tile number to tile row address
  logic [15:0] map_word;
  logic [7:0]  tile;
  logic [tbpf_pkg::VramWordAw-1:0] row_word;

  assign tile = s1_bsel_q ? map_word[15:8] : map_word[7:0];
  assign row_word = cfg.unsigned_tiles
                  ? {1'b0, tile, s1_fine_y_q}
                  : {1'b0, tile ^ 8'h80, s1_fine_y_q} + tbpf_pkg::SignedTileWord;

  logic [2:0] s2_fine_x_q;
  logic [7:0] s2_x_q, s2_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en1) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s2_fine_x_q <= s1_fine_x_q;
      s2_x_q      <= s1_x_q;
      s2_y_q      <= s1_y_q;
    end
  end

  // Video RAM: writes at transfer, map read in stage 0, row read in stage 1
  logic [15:0] row_pair;

  tbpf_vram u_vram (
    .clk_i       (clk_i),
    .wr_en_i     (in_xfer && (in_data_i.kind == tbpf_pkg::KindWrite)),
    .wr_addr_i   (in_data_i.vram_addr),
    .wr_data_i   (in_data_i.vram_byte),
    .rd_a_en_i   (en0),
    .rd_a_addr_i (map_addr[tbpf_pkg::VramAw-1:1]),
    .rd_a_data_o (map_word),
    .rd_b_en_i   (en1),
    .rd_b_addr_i (row_word),
    .rd_b_data_o (row_pair)
  );

  // Stage 2: select the pixel bit from both bitplanes
  logic [2:0] bit_sel;
  logic [1:0] color;

  assign bit_sel = 3'd7 - s2_fine_x_q;
  assign color   = {row_pair[8 + bit_sel], row_pair[bit_sel]};

  tbpf_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en2) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      out_q.color_index <= color;
      out_q.shade       <= tbpf_pkg::shade_of(color);
      out_q.out_x       <= s2_x_q;
      out_q.out_y       <= s2_y_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // Input back-pressure only when every stage is full and the output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && s2_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled with a free pipeline slot");

  // An on-screen render transfer enters stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_data_i.kind == tbpf_pkg::KindRender && on_screen) |=> s1_valid_q)
    else $error("render item lost at stage 1");

  // A write transfer never produces a pipeline item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_data_i.kind == tbpf_pkg::KindWrite) |=> !s1_valid_q)
    else $error("write item entered the render pipeline");

  // A stalled stage 1 item keeps its position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !en1) |=> (s1_valid_q && $stable(s1_x_q) && $stable(s1_y_q)))
    else $error("stage 1 item changed while stalled");
`endif

endmodule

// ===== rtl/tbpf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tbpf_cfg_regs
// Scroll, map select and tile addressing mode registers behind a write port.
// ----------------------------------------------------------------------------
module tbpf_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tbpf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tbpf_pkg::CfgDataW-1:0]  cfg_data_i,
  output tbpf_pkg::cfg_t                 cfg_o
);

  tbpf_pkg::cfg_t cfg_q, cfg_d;

  // Decode the register index and update the selected field
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tbpf_pkg::RegScrollX:       cfg_d.hscroll        = cfg_data_i;
        tbpf_pkg::RegScrollY:       cfg_d.vscroll        = cfg_data_i;
        tbpf_pkg::RegMapSelect:     cfg_d.map_select     = cfg_data_i[0];
        tbpf_pkg::RegUnsignedTiles: cfg_d.unsigned_tiles = cfg_data_i[0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/tbpf_vram.sv =====
// ----------------------------------------------------------------------------
// tbpf_vram
// Video RAM as even and odd byte banks: one byte write and two registered
// 16-bit word reads per cycle. A read at the write address returns old data.
// ----------------------------------------------------------------------------
module tbpf_vram (
  input  logic                               clk_i,
  input  logic                               wr_en_i,
  input  logic [tbpf_pkg::VramAw-1:0]        wr_addr_i,
  input  logic [7:0]                         wr_data_i,
  input  logic                               rd_a_en_i,
  input  logic [tbpf_pkg::VramWordAw-1:0]    rd_a_addr_i,
  output logic [15:0]                        rd_a_data_o,
  input  logic                               rd_b_en_i,
  input  logic [tbpf_pkg::VramWordAw-1:0]    rd_b_addr_i,
  output logic [15:0]                        rd_b_data_o
);

  logic [7:0] mem_lo [tbpf_pkg::VramWords];
  logic [7:0] mem_hi [tbpf_pkg::VramWords];

  logic [tbpf_pkg::VramWordAw-1:0] wr_word;
  assign wr_word = wr_addr_i[tbpf_pkg::VramAw-1:1];

  // Store one byte in its bank, read both word pairs from the two banks
  always_ff @(posedge clk_i) begin
    if (wr_en_i && !wr_addr_i[0]) begin
      mem_lo[wr_word] <= wr_data_i;
    end
    if (wr_en_i && wr_addr_i[0]) begin
      mem_hi[wr_word] <= wr_data_i;
    end
    if (rd_a_en_i) begin
      rd_a_data_o <= {mem_hi[rd_a_addr_i], mem_lo[rd_a_addr_i]};
    end
    if (rd_b_en_i) begin
      rd_b_data_o <= {mem_hi[rd_b_addr_i], mem_lo[rd_b_addr_i]};
    end
  end

endmodule
